// ===== design/cscan_pkg.sv =====
`default_nettype none
package cscan_pkg;

	localparam int unsigned REQ_W     = 16;
	localparam int unsigned DISK_W    = 17;
	localparam int unsigned TOTAL_W   = 18;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DISK_CYL   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_START = 1'b1;

	localparam logic [DISK_W-1:0] DISK_CYL_RST   = 17'd200;
	localparam logic [REQ_W-1:0]  HEAD_START_RST = 16'd0;

	typedef enum logic [KIND_W-1:0] {
		KIND_SERVE = 2'd0,
		KIND_END   = 2'd1,
		KIND_WRAP  = 2'd2
	} step_kind_t;

	// command broadcast along the sorting chain
	typedef struct packed {
		logic ins;
		logic rot;
	} chain_cmd_t;

endpackage
`default_nettype wire

// ===== design/cscan_if.sv =====
`default_nettype none
interface cscan_req_if import cscan_pkg::*;;
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] request_cylinder;
	logic             batch_last;

	modport source (output valid, request_cylinder, batch_last, input ready);
	modport sink (input valid, request_cylinder, batch_last, output ready);
endinterface

interface cscan_rsp_if import cscan_pkg::*;;
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   served_cylinder;
	logic [REQ_W-1:0]   step_movement;
	logic [TOTAL_W-1:0] running_total;
	logic [KIND_W-1:0]  step_kind;
	logic               final_step;

	modport source (output valid, served_cylinder, step_movement, running_total, step_kind,
		final_step, input ready);
	modport sink (input valid, served_cylinder, step_movement, running_total, step_kind,
		final_step, output ready);
endinterface

interface cscan_cfg_if import cscan_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DISK_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/cscan_cell.sv =====
`default_nettype none
module cscan_cell import cscan_pkg::*; (
	input  wire logic             clk,
	input  wire chain_cmd_t       cmd,
	input  wire logic [REQ_W-1:0] req_val,
	input  wire logic             vld,
	input  wire logic             prev_vld,
	input  wire logic             prev_gt,
	input  wire logic [REQ_W-1:0] prev_val,
	input  wire logic [REQ_W-1:0] rot_val,
	output logic      [REQ_W-1:0] val,
	output logic                  gt
);

	logic [REQ_W-1:0] val_q;

	assign val = val_q;
	assign gt  = vld && (val_q > req_val);

	// insert: shift right where larger, first larger or first empty slot takes the request
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || (!vld && prev_vld)) begin
				val_q <= req_val;
			end
		end else if (cmd.rot) begin
			val_q <= rot_val;
		end
	end

endmodule
`default_nettype wire

// ===== design/cscan_chain.sv =====
`default_nettype none
module cscan_chain import cscan_pkg::*; #(
	parameter int unsigned DEPTH = 32,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire chain_cmd_t       cmd,
	input  wire logic [REQ_W-1:0] req_val,
	input  wire logic [CNT_W-1:0] cnt,
	output logic      [REQ_W-1:0] first_val
);

	logic [REQ_W-1:0] vals [DEPTH];
	logic [REQ_W-1:0] rots [DEPTH];
	logic             gts  [DEPTH];
	logic             vlds [DEPTH];

	assign first_val = vals[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] POS  = CNT_W'(i);
		localparam logic [CNT_W-1:0] NEXT = CNT_W'(i + 1);

		assign vlds[i] = POS < cnt;

		// rotation closes the ring at the last occupied cell
		if (i == DEPTH - 1) begin : g_tail
			assign rots[i] = vals[0];
		end else begin : g_mid
			assign rots[i] = (NEXT == cnt) ? vals[0] : vals[i+1];
		end

		if (i == 0) begin : g_head
			cscan_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.req_val  (req_val),
				.vld      (vlds[i]),
				.prev_vld (1'b1),
				.prev_gt  (1'b0),
				.prev_val (req_val),
				.rot_val  (rots[i]),
				.val      (vals[i]),
				.gt       (gts[i])
			);
		end else begin : g_body
			cscan_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.req_val  (req_val),
				.vld      (vlds[i]),
				.prev_vld (vlds[i-1]),
				.prev_gt  (gts[i-1]),
				.prev_val (vals[i-1]),
				.rot_val  (rots[i]),
				.val      (vals[i]),
				.gt       (gts[i])
			);
		end
	end

endmodule
`default_nettype wire

// ===== design/cscan_disk_scheduler_unit.sv =====
// C-SCAN disk scheduler. Requests load one per cycle into a chain of compare-and-shift
// cells that keeps them sorted; up to MAX_REQUESTS per batch are held, later ones are
// dropped. The request marked batch_last starts the schedule and input ready stays low
// until the last result has been handed to the output register. The schedule rotates
// the ring of occupied cells one entry per cycle past cell 0, holding while a stalled
// output blocks a result: it first moves the requests below head_start to the back,
// with a decision step after that skip and after any ascending pass. Results are
// requests at or above the head in ascending order, a sweep to disk_cylinders-1, a
// wrap to 0, then the requests below the head. Requests beyond the disk are clamped
// to the top cylinder. Configuration writes are always accepted and are sampled
// when a batch starts scheduling.
`default_nettype none
module cscan_disk_scheduler_unit import cscan_pkg::*; #(
	parameter int unsigned MAX_REQUESTS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	cscan_req_if.sink     req,
	cscan_rsp_if.source   rsp,
	cscan_cfg_if.sink     cfg
);

	localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SKIP,
		ST_HIGH,
		ST_END,
		ST_WRAP,
		ST_LOW
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   low_q;
	logic [DISK_W-1:0]  disk_cyl_q;
	logic [REQ_W-1:0]   head_start_q;
	logic [REQ_W-1:0]   hst_q;
	logic [REQ_W-1:0]   top_q;
	logic [REQ_W-1:0]   head_q;
	logic [TOTAL_W-1:0] sum_q;

	logic               out_valid_q;
	logic [REQ_W-1:0]   out_cyl_q;
	logic [REQ_W-1:0]   out_mv_q;
	logic [TOTAL_W-1:0] out_total_q;
	step_kind_t         out_kind_q;
	logic               out_final_q;

	chain_cmd_t         cmd;
	logic [REQ_W-1:0]   first_val;
	logic [REQ_W-1:0]   clamped;
	logic [REQ_W-1:0]   top_now;
	logic [REQ_W-1:0]   cur_cyl;
	logic [REQ_W-1:0]   cur_mv;
	logic               out_free;
	logic               in_acc;
	logic               not_full;
	logic               emit;
	logic [CNT_W-1:0]   cnt_next;

	assign req.ready = (state_q == ST_LOAD);
	assign cfg.ready = 1'b1;

	assign rsp.valid           = out_valid_q;
	assign rsp.served_cylinder = out_cyl_q;
	assign rsp.step_movement   = out_mv_q;
	assign rsp.running_total   = out_total_q;
	assign rsp.step_kind       = out_kind_q;
	assign rsp.final_step      = out_final_q;

	assign out_free = !out_valid_q || rsp.ready;
	assign in_acc   = req.valid && req.ready;
	assign not_full = cnt_q < CNT_MAX;
	assign cnt_next = not_full ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		if (disk_cyl_q == '0) begin
			top_now = '0;
		end else if (disk_cyl_q[DISK_W-1]) begin
			top_now = '1;
		end else begin
			top_now = disk_cyl_q[REQ_W-1:0] - REQ_W'(1);
		end
	end

	assign clamped = (first_val > top_q) ? top_q : first_val;

	always_comb begin
		case (state_q)
			ST_END:  cur_cyl = top_q;
			ST_WRAP: cur_cyl = '0;
			default: cur_cyl = clamped;
		endcase
		if (state_q == ST_WRAP) begin
			cur_mv = top_q;
		end else if (cur_cyl >= head_q) begin
			cur_mv = cur_cyl - head_q;
		end else begin
			cur_mv = head_q - cur_cyl;
		end
	end

	always_comb begin
		emit = 1'b0;
		case (state_q)
			ST_HIGH: emit = out_free && (rem_q != '0);
			ST_END,
			ST_WRAP,
			ST_LOW:  emit = out_free;
			default: emit = 1'b0;
		endcase
	end

	always_comb begin
		cmd.ins = in_acc && not_full;
		cmd.rot = 1'b0;
		case (state_q)
			ST_SKIP: cmd.rot = (rem_q != '0) && (clamped < hst_q);
			ST_HIGH,
			ST_LOW:  cmd.rot = emit;
			default: cmd.rot = 1'b0;
		endcase
	end

	cscan_chain #(
		.DEPTH (MAX_REQUESTS)
	) u_chain (
		.clk       (clk),
		.cmd       (cmd),
		.req_val   (req.request_cylinder),
		.cnt       (cnt_q),
		.first_val (first_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_cyl_q   <= DISK_CYL_RST;
			head_start_q <= HEAD_START_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DISK_CYL:   disk_cyl_q   <= cfg.data;
				REG_HEAD_START: head_start_q <= cfg.data[REQ_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			rem_q       <= '0;
			low_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				sum_q <= sum_q + TOTAL_W'(cur_mv);
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_next;
						if (req.batch_last) begin
							rem_q   <= cnt_next;
							low_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_SKIP;
						end
					end
				end
				ST_SKIP: begin
					if (rem_q == '0) begin
						state_q <= ST_END;
					end else if (clamped < hst_q) begin
						rem_q <= rem_q - CNT_W'(1);
						low_q <= low_q + CNT_W'(1);
					end else begin
						state_q <= ST_HIGH;
					end
				end
				ST_HIGH: begin
					if (rem_q == '0) begin
						state_q <= ST_END;
					end else if (emit) begin
						rem_q <= rem_q - CNT_W'(1);
					end
				end
				ST_END: begin
					if (emit) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (emit) begin
						rem_q <= low_q;
						if (low_q == '0) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_LOW;
						end
					end
				end
				ST_LOW: begin
					if (emit) begin
						rem_q <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && req.batch_last) begin
			hst_q  <= head_start_q;
			head_q <= head_start_q;
			top_q  <= top_now;
		end else if (emit) begin
			head_q <= cur_cyl;
		end
		if (emit) begin
			out_cyl_q   <= cur_cyl;
			out_mv_q    <= cur_mv;
			out_total_q <= sum_q + TOTAL_W'(cur_mv);
			case (state_q)
				ST_END:  out_kind_q <= KIND_END;
				ST_WRAP: out_kind_q <= KIND_WRAP;
				default: out_kind_q <= KIND_SERVE;
			endcase
			case (state_q)
				ST_WRAP: out_final_q <= (low_q == '0);
				ST_LOW:  out_final_q <= (rem_q == CNT_W'(1));
				default: out_final_q <= 1'b0;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/cscan_chk.sv =====
`default_nettype none
module cscan_chk import cscan_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic [REQ_W-1:0]   served_cylinder,
	input wire logic [REQ_W-1:0]   step_movement,
	input wire logic [TOTAL_W-1:0] running_total,
	input wire logic [KIND_W-1:0]  step_kind,
	input wire logic               final_step
);

	logic               rsp_acc;
	logic               first_q;
	logic [TOTAL_W-1:0] total_q;

	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			total_q <= '0;
		end else if (rsp_acc) begin
			first_q <= final_step;
			total_q <= running_total;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(running_total))
		else $error("result changed while stalled");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc |-> running_total == (first_q ? TOTAL_W'(step_movement)
			: TOTAL_W'(total_q + TOTAL_W'(step_movement))))
		else $error("running total does not accumulate step movement");

	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && step_kind == KIND_WRAP |-> served_cylinder == '0)
		else $error("wrap step not at cylinder zero");

	a_end_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && step_kind == KIND_END |-> !final_step)
		else $error("sweep step marked final");

endmodule

bind cscan_disk_scheduler_unit cscan_chk u_cscan_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.served_cylinder (rsp.served_cylinder),
	.step_movement   (rsp.step_movement),
	.running_total   (rsp.running_total),
	.step_kind       (rsp.step_kind),
	.final_step      (rsp.final_step)
);
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
	import cscan_pkg::*;

	localparam int MAX_REQ = 32;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic [REQ_W-1:0] cyl;
		logic             last;
	} disk_req_t;

	typedef struct packed {
		logic [REQ_W-1:0]   cyl;
		logic [REQ_W-1:0]   move;
		logic [TOTAL_W-1:0] total;
		step_kind_t         kind;
		logic               fin;
	} head_step_t;

	logic clk;
	logic arst_n;

	cscan_req_if req_bus();
	cscan_rsp_if rsp_bus();
	cscan_cfg_if cfg_bus();

	cscan_disk_scheduler_unit #(.MAX_REQUESTS(MAX_REQ)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	disk_req_t         req_backlog[$];
	head_step_t        expected_steps[$];
	logic [REQ_W-1:0]  held_reqs[$];
	logic [DISK_W-1:0] cfg_disk;
	logic [REQ_W-1:0]  cfg_head;
	disk_req_t         on_bus;
	int                req_hold;
	int                rsp_hold;
	int                req_idle_mode;
	int                rsp_idle_mode;
	int                sent_items;
	int                bad_steps;
	int                quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int disk_top(input logic [DISK_W-1:0] d);
		if (d == '0) return 0;
		if (d > 17'd65536) return 65535;
		return int'(d) - 1;
	endfunction

	// 0: never idle, 1: a random wait after every transaction, 2: occasional waits from the same range
	function automatic int draw_wait(input int mode);
		if (mode == 0) return 0;
		if (mode == 1) return $urandom_range(0, 17);
		return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
	endfunction

	task automatic schedule_request(input disk_req_t r);
		int pos;
		int top;
		int at;
		int mv;
		int split;
		int clamped[$];
		int tgt[$];
		step_kind_t knd[$];
		logic [TOTAL_W-1:0] sum;
		head_step_t s;
		if (held_reqs.size() < MAX_REQ) begin
			pos = 0;
			while (pos < held_reqs.size() && held_reqs[pos] <= r.cyl)
				pos++;
			held_reqs.insert(pos, r.cyl);
		end
		if (!r.last)
			return;
		top = disk_top(cfg_disk);
		foreach (held_reqs[i])
			clamped.push_back((int'(held_reqs[i]) > top) ? top : int'(held_reqs[i]));
		split = clamped.size();
		foreach (clamped[i]) begin
			if (clamped[i] >= int'(cfg_head)) begin
				split = i;
				break;
			end
		end
		for (int i = split; i < clamped.size(); i++) begin
			tgt.push_back(clamped[i]);
			knd.push_back(KIND_SERVE);
		end
		tgt.push_back(top);
		knd.push_back(KIND_END);
		tgt.push_back(0);
		knd.push_back(KIND_WRAP);
		for (int i = 0; i < split; i++) begin
			tgt.push_back(clamped[i]);
			knd.push_back(KIND_SERVE);
		end
		at = cfg_head;
		sum = '0;
		foreach (tgt[j]) begin
			mv = (tgt[j] > at) ? tgt[j] - at : at - tgt[j];
			sum = sum + TOTAL_W'(mv);
			s.cyl = REQ_W'(tgt[j]);
			s.move = REQ_W'(mv);
			s.total = sum;
			s.kind = knd[j];
			s.fin = (j == tgt.size() - 1);
			expected_steps.push_back(s);
			at = tgt[j];
		end
		held_reqs.delete();
	endtask

	task automatic add_batch(input int vals[$]);
		disk_req_t r;
		foreach (vals[i]) begin
			r.cyl = REQ_W'(vals[i]);
			r.last = (i == vals.size() - 1);
			req_backlog.push_back(r);
			sent_items++;
		end
	endtask

	task automatic settle();
		do @(posedge clk);
		while (req_backlog.size() != 0 || req_bus.valid || expected_steps.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [DISK_W-1:0] d, input logic [REQ_W-1:0] h);
		settle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= REG_DISK_CYL;
		cfg_bus.data <= d;
		do @(posedge clk);
		while (!cfg_bus.ready);
		cfg_disk = d;
		cfg_bus.index <= REG_HEAD_START;
		cfg_bus.data <= DISK_W'(h);
		do @(posedge clk);
		while (!cfg_bus.ready);
		cfg_head = h;
		cfg_bus.valid <= 1'b0;
	endtask

	// request side
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				schedule_request(on_bus);
				req_hold = draw_wait(req_idle_mode);
			end
			if (req_bus.valid && !req_bus.ready) begin
				// hold current transaction
			end else if (req_hold > 0) begin
				req_hold--;
				req_bus.valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				on_bus = req_backlog.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.request_cylinder <= on_bus.cyl;
				req_bus.batch_last <= on_bus.last;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// result side
	always @(posedge clk) begin
		head_step_t got;
		head_step_t want;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.cyl = rsp_bus.served_cylinder;
				got.move = rsp_bus.step_movement;
				got.total = rsp_bus.running_total;
				got.kind = step_kind_t'(rsp_bus.step_kind);
				got.fin = rsp_bus.final_step;
				if (expected_steps.size() == 0) begin
					if (bad_steps < 10)
						$display("unexpected step: cyl=%0d move=%0d total=%0d kind=%0d fin=%0d",
							got.cyl, got.move, got.total, got.kind, got.fin);
					bad_steps++;
				end else begin
					want = expected_steps.pop_front();
					if (got.cyl !== want.cyl || got.move !== want.move ||
						got.total !== want.total || got.kind !== want.kind ||
						got.fin !== want.fin) begin
						if (bad_steps < 10)
							$display({"step mismatch: expected cyl=%0d move=%0d total=%0d ",
								"kind=%0d fin=%0d, got cyl=%0d move=%0d total=%0d kind=%0d fin=%0d"},
								want.cyl, want.move, want.total, want.kind, want.fin,
								got.cyl, got.move, got.total, got.kind, got.fin);
						bad_steps++;
					end
				end
				rsp_hold = draw_wait(rsp_idle_mode);
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	initial begin
		int d;
		int h;
		int top;
		int len;
		int v;
		int vals[$];
		bit first;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.request_cylinder = '0;
		req_bus.batch_last = 1'b0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_DISK_CYL;
		cfg_bus.data = '0;
		cfg_disk = DISK_CYL_RST;
		cfg_head = HEAD_START_RST;
		req_hold = 0;
		rsp_hold = 0;
		req_idle_mode = 1;
		rsp_idle_mode = 1;
		sent_items = 0;
		bad_steps = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: clamp above the disk, nothing below the head
		add_batch({50, 199, 0, 300, 120});
		add_batch({65535});
		// largest disk, head at the top cylinder
		reconfigure(17'd65536, 16'd65535);
		add_batch({65535, 0, 32768, 1});
		// zero-size disk treated as one cylinder, head above the top
		reconfigure(17'd0, 16'd5);
		add_batch({7, 0});
		// oversized disk value
		reconfigure(17'd131071, 16'd100);
		add_batch({100, 99, 65535});
		reconfigure(17'd10, 16'd65535);
		add_batch({3, 12, 9});
		reconfigure(17'd1, 16'd0);
		add_batch({0});

		first = 1'b1;
		while (sent_items < 345) begin
			case ($urandom_range(0, 7))
				0: d = 0;
				1: d = 1;
				2: d = 65536;
				3: d = 131071;
				4: d = 200;
				5: d = $urandom_range(2, 300);
				default: d = $urandom_range(1, 65536);
			endcase
			top = disk_top(DISK_W'(d));
			case ($urandom_range(0, 4))
				0: h = 0;
				1: h = 65535;
				2: h = $urandom_range(0, top);
				default: h = $urandom_range(0, 65535);
			endcase
			reconfigure(DISK_W'(d), REQ_W'(h));
			req_idle_mode = first ? 0 : $urandom_range(0, 2);
			rsp_idle_mode = first ? 0 : $urandom_range(0, 2);
			first = 1'b0;
			repeat ($urandom_range(2, 6)) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
				vals.delete();
				repeat (len) begin
					case ($urandom_range(0, 3))
						0: v = $urandom_range(0, 65535);
						1: v = $urandom_range(0, top);
						2: begin
							v = h + $urandom_range(0, 8) - 4;
							if (v < 0) v = 0;
							if (v > 65535) v = 65535;
						end
						default: v = $urandom_range(0, 1) ? top : h;
					endcase
					vals.push_back(v);
				end
				add_batch(vals);
			end
		end
		settle();

		if (bad_steps == 0 && expected_steps.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
